/* rtl/oal_pkg.sv */
// shared types and constants for the ordered array list engine
package oal_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int POS_BITS  = 5;
  localparam int CMP_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

  typedef enum logic [3:0] {
    MODE_PUSH_BACK  = 4'd0,
    MODE_PUSH_FRONT = 4'd1,
    MODE_POP_BACK   = 4'd2,
    MODE_POP_FRONT  = 4'd3,
    MODE_INSERT     = 4'd4,
    MODE_REMOVE     = 4'd5,
    MODE_READ       = 4'd6,
    MODE_WRITE      = 4'd7,
    MODE_CLEAR      = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_OPEN,
    DP_CLOSE,
    DP_WRITE,
    DP_DROP,
    DP_CLEAR,
    DP_READ
  } dp_op_e;

  typedef enum logic [1:0] {
    IDX_COUNT,
    IDX_ZERO,
    IDX_POS,
    IDX_MATCH
  } idx_sel_e;

  typedef struct packed {
    logic [3:0]            mode;
    logic signed [31:0]    value;
    logic [POS_BITS-1:0]   position;
  } in_t;

  typedef struct packed {
    logic signed [31:0]    read_data;
    logic [2:0]            status;
    logic [4:0]            entry_count;
    logic                  is_empty;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     exec;
    dp_op_e   op;
    idx_sel_e idx_sel;
    status_e  status;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       full;
    logic       empty;
    logic       pos_le_count;
    logic       pos_lt_count;
    logic       found;
  } stat_t;

endpackage

/* rtl/oal_ctrl.sv */
// controller: accepts an item, decodes it against datapath status, issues one command
module oal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  oal_pkg::stat_t stat_i,
  output oal_pkg::cmd_t  cmd_o,
  output logic          done_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  assign busy   = (state_q == S_EXEC);
  assign done_o = done_q;

  always_comb begin
    state_d       = state_q;
    done_d        = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.op      = oal_pkg::DP_NONE;
    cmd_o.idx_sel = oal_pkg::IDX_POS;
    cmd_o.status  = oal_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
        case (stat_i.mode)
          oal_pkg::MODE_PUSH_BACK: begin
            if (stat_i.full) cmd_o.status = oal_pkg::ST_FULL;
            else begin
              cmd_o.op      = oal_pkg::DP_OPEN;
              cmd_o.idx_sel = oal_pkg::IDX_COUNT;
            end
          end
          oal_pkg::MODE_PUSH_FRONT: begin
            if (stat_i.full) cmd_o.status = oal_pkg::ST_FULL;
            else begin
              cmd_o.op      = oal_pkg::DP_OPEN;
              cmd_o.idx_sel = oal_pkg::IDX_ZERO;
            end
          end
          oal_pkg::MODE_POP_BACK: begin
            if (stat_i.empty) cmd_o.status = oal_pkg::ST_EMPTY;
            else cmd_o.op = oal_pkg::DP_DROP;
          end
          oal_pkg::MODE_POP_FRONT: begin
            if (stat_i.empty) cmd_o.status = oal_pkg::ST_EMPTY;
            else begin
              cmd_o.op      = oal_pkg::DP_CLOSE;
              cmd_o.idx_sel = oal_pkg::IDX_ZERO;
            end
          end
          oal_pkg::MODE_INSERT: begin
            // position is checked before fullness
            if (!stat_i.pos_le_count) cmd_o.status = oal_pkg::ST_BADPOS;
            else if (stat_i.full) cmd_o.status = oal_pkg::ST_FULL;
            else cmd_o.op = oal_pkg::DP_OPEN;
          end
          oal_pkg::MODE_REMOVE: begin
            if (stat_i.empty) cmd_o.status = oal_pkg::ST_EMPTY;
            else if (!stat_i.found) cmd_o.status = oal_pkg::ST_NOTFOUND;
            else begin
              cmd_o.op      = oal_pkg::DP_CLOSE;
              cmd_o.idx_sel = oal_pkg::IDX_MATCH;
            end
          end
          oal_pkg::MODE_READ: begin
            if (!stat_i.pos_lt_count) cmd_o.status = oal_pkg::ST_BADPOS;
            else cmd_o.op = oal_pkg::DP_READ;
          end
          oal_pkg::MODE_WRITE: begin
            if (!stat_i.pos_lt_count) cmd_o.status = oal_pkg::ST_BADPOS;
            else cmd_o.op = oal_pkg::DP_WRITE;
          end
          oal_pkg::MODE_CLEAR: cmd_o.op = oal_pkg::DP_CLEAR;
          default: cmd_o.op = oal_pkg::DP_NONE;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

/* rtl/oal_dp.sv */
// datapath: row of cells with parallel shift and match, count and result registers
module oal_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  oal_pkg::in_t   item_i,
  input  oal_pkg::cmd_t  cmd_i,
  output oal_pkg::stat_t stat_o,
  output oal_pkg::out_t  result_o
);

  oal_pkg::in_t item_q;
  logic [oal_pkg::WORD_BITS-1:0] cells_q [oal_pkg::DEPTH];
  logic [oal_pkg::WORD_BITS-1:0] cells_d [oal_pkg::DEPTH];
  logic [oal_pkg::CNT_BITS-1:0]  count_q, count_d;
  oal_pkg::out_t                 result_q, result_d;

  logic [oal_pkg::WORD_BITS-1:0] word;
  logic [oal_pkg::CMP_BITS-1:0]  pos_w, cnt_w;
  logic [oal_pkg::DEPTH-1:0]     hit, first_oh;
  logic [oal_pkg::IDX_BITS-1:0]  match_idx, idx;

  assign word  = item_q.value[oal_pkg::WORD_BITS-1:0];
  assign pos_w = oal_pkg::CMP_BITS'(item_q.position);
  assign cnt_w = oal_pkg::CMP_BITS'(count_q);

  // compare every live cell at once, keep the lowest hit
  always_comb begin
    for (int i = 0; i < oal_pkg::DEPTH; i++) begin
      hit[i] = (count_q > oal_pkg::CNT_BITS'(i)) && (cells_q[i] == word);
    end
    first_oh  = hit & (~hit + 1'b1);
    match_idx = '0;
    for (int i = 0; i < oal_pkg::DEPTH; i++) begin
      if (first_oh[i]) match_idx = match_idx | oal_pkg::IDX_BITS'(i);
    end
  end

  always_comb begin
    stat_o.mode         = item_q.mode;
    stat_o.full         = (count_q == oal_pkg::CNT_BITS'(oal_pkg::DEPTH));
    stat_o.empty        = (count_q == '0);
    stat_o.pos_le_count = (pos_w <= cnt_w);
    stat_o.pos_lt_count = (pos_w < cnt_w);
    stat_o.found        = |hit;
  end

  always_comb begin
    case (cmd_i.idx_sel)
      oal_pkg::IDX_COUNT: idx = count_q[oal_pkg::IDX_BITS-1:0];
      oal_pkg::IDX_ZERO:  idx = '0;
      oal_pkg::IDX_MATCH: idx = match_idx;
      default:            idx = pos_w[oal_pkg::IDX_BITS-1:0];
    endcase
  end

  always_comb begin
    cells_d = cells_q;
    count_d = count_q;
    result_d.read_data = '0;
    case (cmd_i.op)
      oal_pkg::DP_OPEN: begin
        for (int i = 1; i < oal_pkg::DEPTH; i++) begin
          if (oal_pkg::IDX_BITS'(i) > idx) cells_d[i] = cells_q[i-1];
        end
        cells_d[idx] = word;
        count_d = count_q + 1'b1;
      end
      oal_pkg::DP_CLOSE: begin
        for (int i = 0; i < oal_pkg::DEPTH - 1; i++) begin
          if (oal_pkg::IDX_BITS'(i) >= idx) cells_d[i] = cells_q[i+1];
        end
        count_d = count_q - 1'b1;
      end
      oal_pkg::DP_WRITE: cells_d[idx] = word;
      oal_pkg::DP_DROP:  count_d = count_q - 1'b1;
      oal_pkg::DP_CLEAR: count_d = '0;
      oal_pkg::DP_READ:  result_d.read_data = 32'($signed(cells_q[idx]));
      default: ;
    endcase
    result_d.status      = cmd_i.status;
    result_d.entry_count = 5'(count_d);
    result_d.is_empty    = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.exec) begin
      cells_q  <= cells_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

/* rtl/ordered_array_list_engine_top.sv */
// top level of the ordered array list engine: controller plus datapath
// an item is taken when start is high and busy low; busy then stays high one cycle
// the result strobe is registered from the execute state, lasts one cycle, never stalls
// a new item is not taken while busy: each item passes an accept cycle and then an execute cycle
// all shifts and the match search act on the whole row of cells in the execute cycle
// reset clears the count and the controller; cell contents are kept until written
module ordered_array_list_engine_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  oal_pkg::in_t  item_i,
  output logic          result_valid_o,
  output oal_pkg::out_t result_o
);

  oal_pkg::cmd_t  cmd;
  oal_pkg::stat_t stat;

  oal_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd),
    .done_o (result_valid_o)
  );

  oal_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

  // every accepted transfer enters the execute cycle next
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not enter execute");

  // each execute cycle yields exactly one result strobe
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (result_valid_o && !busy))
    else $error("execute cycle without result strobe");

  // no result appears without an execute cycle before it
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without execute");

  // empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.is_empty == (result_o.entry_count == 5'd0)))
    else $error("empty flag disagrees with count");

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the ordered array list engine: directed table then random traffic
`timescale 1ns / 100ps

module tb_top;

  localparam logic [3:0] MODE_SPARE_LO = 4'd9;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;
  localparam int RAND_ITEMS   = 850;
  localparam int PHASE_LEN    = 85;
  localparam int MAX_PRINTS   = 40;
  localparam int SCRIPT_ROWS  = 32;
  localparam int EXP_DEPTH    = 16;
  localparam int EXP_IDX_BITS = 4;

  typedef struct {
    oal_pkg::in_t  op;
    bit            typed;
    oal_pkg::out_t want;
  } step_row_t;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  logic          busy;
  oal_pkg::in_t  item_i = '0;
  logic          result_valid_o;
  oal_pkg::out_t result_o;

  // predictor state: shadow of the stored row and its fill level
  logic [31:0] list_cells [oal_pkg::DEPTH];
  int unsigned list_count = 0;

  // expected results waiting for their strobe, kept in a small ring
  oal_pkg::out_t           exp_ring [EXP_DEPTH];
  logic [EXP_IDX_BITS:0]   exp_wr = '0;
  logic [EXP_IDX_BITS:0]   exp_rd = '0;

  step_row_t script [SCRIPT_ROWS];
  int        n_rows = 0;

  int n_errors   = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int peak_fill  = 0;
  int n_full     = 0;
  int n_notfound = 0;
  int n_badpos   = 0;

  ordered_array_list_engine_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int outstanding();
    logic [EXP_IDX_BITS:0] diff;
    diff = exp_wr - exp_rd;
    return int'(diff);
  endfunction

  initial begin
    #2_000_000;
    $display("timeout after %0d transfers, %0d results outstanding", n_sent,
             outstanding());
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t mismatch on result %0d, %s: got %h want %h", $realtime, n_checked,
               what, got, want);
  endtask

  function automatic void open_slot(int unsigned at, logic [31:0] w);
    for (int unsigned i = list_count; i > at; i--) list_cells[i] = list_cells[i-1];
    list_cells[at] = w;
    list_count++;
  endfunction

  function automatic void close_slot(int unsigned at);
    for (int unsigned i = at; i + 1 < list_count; i++) list_cells[i] = list_cells[i+1];
    list_count--;
  endfunction

  // applies one operation to the shadow list and returns the result it should give
  function automatic oal_pkg::out_t apply_list_op(oal_pkg::in_t it);
    oal_pkg::out_t r;
    logic [31:0]   w;
    int unsigned   pos;
    bit            hit;
    r   = '0;
    w   = it.value;
    pos = it.position;
    hit = 1'b0;
    r.status = oal_pkg::ST_OK;
    case (it.mode)
      oal_pkg::MODE_PUSH_BACK: begin
        if (list_count >= oal_pkg::DEPTH) r.status = oal_pkg::ST_FULL;
        else open_slot(list_count, w);
      end
      oal_pkg::MODE_PUSH_FRONT: begin
        if (list_count >= oal_pkg::DEPTH) r.status = oal_pkg::ST_FULL;
        else open_slot(0, w);
      end
      oal_pkg::MODE_POP_BACK: begin
        if (list_count == 0) r.status = oal_pkg::ST_EMPTY;
        else list_count--;
      end
      oal_pkg::MODE_POP_FRONT: begin
        if (list_count == 0) r.status = oal_pkg::ST_EMPTY;
        else close_slot(0);
      end
      oal_pkg::MODE_INSERT: begin
        if (pos > list_count) r.status = oal_pkg::ST_BADPOS;
        else if (list_count >= oal_pkg::DEPTH) r.status = oal_pkg::ST_FULL;
        else open_slot(pos, w);
      end
      oal_pkg::MODE_REMOVE: begin
        if (list_count == 0) begin
          r.status = oal_pkg::ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < list_count && !hit; i++) begin
            if (list_cells[i] == w) begin
              close_slot(i);
              hit = 1'b1;
            end
          end
          r.status = hit ? oal_pkg::ST_OK : oal_pkg::ST_NOTFOUND;
        end
      end
      oal_pkg::MODE_READ: begin
        if (pos >= list_count) r.status = oal_pkg::ST_BADPOS;
        else r.read_data = list_cells[pos];
      end
      oal_pkg::MODE_WRITE: begin
        if (pos >= list_count) r.status = oal_pkg::ST_BADPOS;
        else list_cells[pos] = w;
      end
      oal_pkg::MODE_CLEAR: list_count = 0;
      default: ;
    endcase
    r.entry_count = list_count[4:0];
    r.is_empty    = (list_count == 0);
    return r;
  endfunction

  function automatic oal_pkg::in_t mk_item(logic [3:0] m, logic [31:0] v, logic [4:0] p);
    oal_pkg::in_t it;
    it.mode     = m;
    it.value    = v;
    it.position = p;
    return it;
  endfunction

  function automatic oal_pkg::out_t outcome(logic [31:0] rd, oal_pkg::status_e st,
                                            int unsigned cnt);
    oal_pkg::out_t r;
    r.read_data   = rd;
    r.status      = st;
    r.entry_count = cnt[4:0];
    r.is_empty    = (cnt == 0);
    return r;
  endfunction

  task automatic add_row(oal_pkg::in_t op, bit typed, oal_pkg::out_t want);
    step_row_t row;
    row.op    = op;
    row.typed = typed;
    row.want  = want;
    script[n_rows] = row;
    n_rows++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0;
      4, 5:    return $urandom_range(0, 7);  // small pool so duplicates occur
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_mode(logic [3:0] lo, logic [3:0] hi);
    return 4'($urandom_range(32'(lo), 32'(hi)));
  endfunction

  // phase kinds: 0 grow, 1 shrink, 2 mixed, 3 mostly indexed access
  function automatic oal_pkg::in_t pick_op(int kind);
    int unsigned roll;
    logic [3:0]  m;
    logic [31:0] v;
    logic [4:0]  p;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      m = pick_mode(MODE_SPARE_LO, MODE_SPARE_HI);
    end else if (roll < 5 && kind != 0) begin
      m = oal_pkg::MODE_CLEAR;
    end else begin
      case (kind)
        0: m = ($urandom_range(0, 99) < 70) ?
               pick_mode(oal_pkg::MODE_PUSH_BACK, oal_pkg::MODE_PUSH_FRONT) :
               pick_mode(oal_pkg::MODE_INSERT, oal_pkg::MODE_WRITE);
        1: m = ($urandom_range(0, 99) < 65) ?
               pick_mode(oal_pkg::MODE_POP_BACK, oal_pkg::MODE_REMOVE) :
               pick_mode(oal_pkg::MODE_PUSH_BACK, oal_pkg::MODE_WRITE);
        3: m = ($urandom_range(0, 99) < 60) ?
               pick_mode(oal_pkg::MODE_READ, oal_pkg::MODE_WRITE) :
               pick_mode(oal_pkg::MODE_PUSH_BACK, oal_pkg::MODE_REMOVE);
        default: m = pick_mode(oal_pkg::MODE_PUSH_BACK, oal_pkg::MODE_WRITE);
      endcase
    end
    v = pick_value();
    // removals mostly aim at a stored word
    if (m == oal_pkg::MODE_REMOVE && list_count > 0 && $urandom_range(0, 99) < 70)
      v = list_cells[$urandom_range(0, list_count - 1)];
    if ($urandom_range(0, 99) < 80) p = 5'($urandom_range(0, list_count));
    else p = 5'($urandom_range(0, 31));
    return mk_item(m, v, p);
  endfunction

  // holds start high until the block takes the item, then books the expectation
  task automatic send_op(oal_pkg::in_t it, bit typed, oal_pkg::out_t want);
    oal_pkg::out_t got;
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    got = apply_list_op(it);
    exp_ring[exp_wr[EXP_IDX_BITS-1:0]] = typed ? want : got;
    exp_wr = exp_wr + 1'b1;
    n_sent++;
    if (int'(list_count) > peak_fill) peak_fill = int'(list_count);
    if (got.status == oal_pkg::ST_FULL) n_full++;
    if (got.status == oal_pkg::ST_NOTFOUND) n_notfound++;
    if (got.status == oal_pkg::ST_BADPOS) n_badpos++;
  endtask

  task automatic hold_off(int cycles, bit drain);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
    if (drain) while (outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 99) < 25) hold_off($urandom_range(1, 4), 1'b0);
  endtask

  always @(posedge clk_i) begin
    oal_pkg::out_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (outstanding() == 0) begin
        report_mismatch("result with no transfer pending", result_o.read_data, '0);
      end else begin
        want   = exp_ring[exp_rd[EXP_IDX_BITS-1:0]];
        exp_rd = exp_rd + 1'b1;
        if (result_o.read_data !== want.read_data)
          report_mismatch("read_data", result_o.read_data, want.read_data);
        if (result_o.status !== want.status)
          report_mismatch("status", 32'(result_o.status), 32'(want.status));
        if (result_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(result_o.entry_count),
                          32'(want.entry_count));
        if (result_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(result_o.is_empty), 32'(want.is_empty));
        n_checked++;
      end
    end
  end

  initial begin
    // empty-list corner cases first, then signed extremes and shifting
    add_row(mk_item(oal_pkg::MODE_POP_BACK, 32'h0, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_EMPTY, 0));
    add_row(mk_item(oal_pkg::MODE_POP_FRONT, 32'h0, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_EMPTY, 0));
    add_row(mk_item(oal_pkg::MODE_REMOVE, 32'h0, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_EMPTY, 0));
    add_row(mk_item(oal_pkg::MODE_READ, 32'h0, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_BADPOS, 0));
    add_row(mk_item(oal_pkg::MODE_WRITE, 32'h1, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_BADPOS, 0));
    add_row(mk_item(oal_pkg::MODE_INSERT, 32'h1, 5'd1), 1,
            outcome(32'h0, oal_pkg::ST_BADPOS, 0));
    add_row(mk_item(oal_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_OK, 1));
    add_row(mk_item(oal_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_OK, 2));
    add_row(mk_item(oal_pkg::MODE_INSERT, 32'hffff_ffff, 5'd2), 1,
            outcome(32'h0, oal_pkg::ST_OK, 3));
    add_row(mk_item(oal_pkg::MODE_INSERT, 32'h0, 5'd1), 1,
            outcome(32'h0, oal_pkg::ST_OK, 4));
    add_row(mk_item(oal_pkg::MODE_READ, 32'h0, 5'd0), 1,
            outcome(32'h8000_0000, oal_pkg::ST_OK, 4));
    add_row(mk_item(oal_pkg::MODE_READ, 32'h0, 5'd3), 1,
            outcome(32'hffff_ffff, oal_pkg::ST_OK, 4));
    add_row(mk_item(oal_pkg::MODE_READ, 32'h0, 5'd4), 1,
            outcome(32'h0, oal_pkg::ST_BADPOS, 4));
    add_row(mk_item(oal_pkg::MODE_WRITE, 32'd12345, 5'd1), 0, '0);
    add_row(mk_item(oal_pkg::MODE_REMOVE, 32'h0, 5'd0), 0, '0);
    add_row(mk_item(oal_pkg::MODE_REMOVE, 32'h7fff_ffff, 5'd0), 0, '0);
    add_row(mk_item(oal_pkg::MODE_POP_FRONT, 32'h0, 5'd0), 0, '0);
    add_row(mk_item(oal_pkg::MODE_POP_BACK, 32'h0, 5'd0), 0, '0);
    add_row(mk_item(MODE_SPARE_HI, 32'hdead_beef, 5'd31), 0, '0);
    add_row(mk_item(MODE_SPARE_LO, 32'h1234_5678, 5'd0), 0, '0);
    add_row(mk_item(oal_pkg::MODE_INSERT, 32'h55aa_55aa, 5'd0), 0, '0);
    add_row(mk_item(oal_pkg::MODE_CLEAR, 32'h0, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_OK, 0));
    add_row(mk_item(oal_pkg::MODE_READ, 32'h0, 5'd31), 1,
            outcome(32'h0, oal_pkg::ST_BADPOS, 0));
    add_row(mk_item(oal_pkg::MODE_INSERT, 32'h0, 5'd31), 1,
            outcome(32'h0, oal_pkg::ST_BADPOS, 0));
    add_row(mk_item(oal_pkg::MODE_REMOVE, 32'h0, 5'd0), 1,
            outcome(32'h0, oal_pkg::ST_EMPTY, 0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < n_rows; i++) begin
      send_op(script[i].op, script[i].typed, script[i].want);
      maybe_idle();
    end
    hold_off(1, 1'b1);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      send_op(pick_op((n / PHASE_LEN) % 4), 1'b0, '0);
      // phase boundary: let the block run dry before the next phase
      if (n % PHASE_LEN == PHASE_LEN - 1) hold_off(1, 1'b1);
      else if (n / PHASE_LEN != 4) maybe_idle();  // phase four runs back to back
    end

    hold_off(1, 1'b1);
    repeat (8) @(posedge clk_i);

    $display("sent %0d transfers, checked %0d results, peak fill %0d of %0d", n_sent,
             n_checked, peak_fill, oal_pkg::DEPTH);
    $display("hit full %0d times, bad position %0d times, no match %0d times", n_full,
             n_badpos, n_notfound);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
